### src/assert_macros.svh
// Assertion macros shared by the edge detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/lapedge_pkg.sv
// Shared types and constants for the Laplacian edge detector.
package lapedge_pkg;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [THR_W-1:0] THR_RST = 8'd128;
  localparam logic [FW_W-1:0]  FW_RST  = 12'd640;
  localparam logic [FH_W-1:0]  FH_RST  = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] edge_threshold;
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    logic edge_res;
    logic end_of_row;
    logic end_of_frame;
  } res_t;

endpackage

### src/lapedge_ram.sv
// Generic single-write, single-read RAM with registered, write-first read.
module lapedge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lapedge_core.sv
// Line buffers, raster counters and the cross Laplacian with threshold.
`include "assert_macros.svh"

module lapedge_core #(
  parameter int MAX_WIDTH = lapedge_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lapedge_pkg::cfg_t              cfg,
  input  logic                           accept,
  input  logic [lapedge_pkg::PIX_W-1:0]  pixel,
  input  logic                           drain,
  output logic                           push,
  output lapedge_pkg::res_t              res
);

  import lapedge_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [CW-1:0]    col;
  logic [CW-1:0]    col_next;
  logic [FH_W-1:0]  row;
  logic [FH_W-1:0]  row_next;
  logic [PIX_W-1:0] left;

  logic [CW-1:0]    raddr_a;
  logic [CW-1:0]    raddr_b;
  logic [PIX_W-1:0] mid_c_q;
  logic [PIX_W-1:0] mid_r_q;
  logic [PIX_W-1:0] up_q;

  logic [CMPW-1:0]  col_inc;
  logic             last_col;
  logic [FH_W-1:0]  h_eff;
  logic [FH_W:0]    row_inc;
  logic             drain_row;
  logic             process;
  logic             emit;
  logic             mid_we;
  logic             up_we;

  logic [PIX_W-1:0] ctr, up, dn, lf, rt;
  logic signed [10:0] lap;
  logic [PIX_W-1:0] lap_clamp;

  // Geometry; width 0 behaves as 1 since c+1 >= 0 always holds.
  assign col_inc   = CMPW'(col) + CMPW'(1);
  assign last_col  = (col_inc >= CMPW'(cfg.frame_width)) || (col == CW'(MAX_WIDTH - 1));
  assign h_eff     = (cfg.frame_height == '0) ? FH_W'(1) : cfg.frame_height;
  assign drain_row = (row >= h_eff);
  assign row_inc   = {1'b0, row} + {{FH_W{1'b0}}, 1'b1};

  // A drain flag during image rows is dropped without touching state.
  assign process = accept && (drain_row || !drain);
  assign emit    = process && (drain_row || (row != '0));
  assign mid_we  = process && !drain_row;
  assign up_we   = mid_we && (row != '0);

  // Window: missing neighbours replicate the centre.
  assign ctr = mid_c_q;
  assign up  = (row == FH_W'(1)) ? ctr : up_q;
  assign dn  = drain_row ? ctr : pixel;
  assign lf  = (col == '0) ? ctr : left;
  assign rt  = last_col ? ctr : mid_r_q;

  assign lap = $signed({1'b0, ctr, 2'b00}) - $signed({3'b000, up}) - $signed({3'b000, dn})
             - $signed({3'b000, lf}) - $signed({3'b000, rt});

  // Negative responses clamp to zero, anything past full scale to 255.
  assign lap_clamp = lap[10] ? '0 : ((lap > 11'sd255) ? '1 : lap[PIX_W-1:0]);

  assign push             = emit;
  assign res.edge_res     = (lap_clamp > cfg.edge_threshold);
  assign res.end_of_row   = last_col;
  assign res.end_of_frame = last_col && drain_row;

  always_comb begin
    col_next = col;
    row_next = row;
    if (process) begin
      if (last_col) begin
        col_next = '0;
        if (drain_row) begin
          row_next = '0;
        end else if (row_inc >= {1'b0, h_eff}) begin
          row_next = h_eff;
        end else begin
          row_next = row_inc[FH_W-1:0];
        end
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  // Reads are issued for the column the next item will use.
  assign raddr_a = col_next;
  assign raddr_b = (col_next == CW'(MAX_WIDTH - 1)) ? col_next : col_next + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      left <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (emit) begin
        left <= ctr;
      end
    end
  end

  lapedge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_c (
    .clk   (clk),
    .we    (mid_we),
    .waddr (col),
    .wdata (pixel),
    .raddr (raddr_a),
    .rdata (mid_c_q)
  );

  lapedge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_r (
    .clk   (clk),
    .we    (mid_we),
    .waddr (col),
    .wdata (pixel),
    .raddr (raddr_b),
    .rdata (mid_r_q)
  );

  lapedge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up (
    .clk   (clk),
    .we    (up_we),
    .waddr (col),
    .wdata (ctr),
    .raddr (raddr_a),
    .rdata (up_q)
  );

  `ASSERT_IMPLIES(a_col_bound, clk, rst, 1'b1, ({1'b0, col} < (CW + 1)'(MAX_WIDTH)))
  `ASSERT_IMPLIES(a_eof_on_eor, clk, rst, push && res.end_of_frame, res.end_of_row)
  `ASSERT_IMPLIES(a_no_emit_idle, clk, rst, !accept, !push && !mid_we)

endmodule

### src/lapedge_skid.sv
// Two-entry output register with skid stage.
`include "assert_macros.svh"

module lapedge_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lapedge_pkg::res_t din,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lapedge_pkg::res_t dout
);

  import lapedge_pkg::*;

  logic skid_valid;
  res_t skid;
  logic take;

  assign ready = !skid_valid;
  assign take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        dout <= skid;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid <= din;
      end else begin
        dout <= din;
      end
    end
  end

  `ASSERT_IMPLIES(a_skid_needs_main, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLIES(a_skid_fill, clk, rst, $rose(skid_valid), $past(out_valid && !out_ready))

endmodule

### src/laplacian_edge_threshold.sv
// Top level of the streaming 3x3 cross-Laplacian edge detector.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata[7:0] pixel, s_tuser drain
//  m_*     | out | m_tvalid / m_tready  | m_tdata[0] edge_res, m_tlast end_of_row,
//          |     |                      | m_tuser end_of_frame
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// One request per clock while s_tready is high: the window is built from
// three line RAM reads issued ahead from the next column, so throughput is
// one item per cycle. A result goes into the output register, or into the
// skid entry while the output is stalled; the image itself lags by one row,
// flushed by a row of drain requests. Reset is synchronous: counters and
// control registers clear, line RAMs are not swept. Output stalls are absorbed
// by a two-entry output buffer; s_tready falls only when both entries are full.
module laplacian_edge_threshold #(
  parameter int MAX_WIDTH = lapedge_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] pixel
  input  logic                                 s_tuser,   // [0] drain
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,   // [0] edge_res, [7:1] zero
  output logic                                 m_tlast,   // end_of_row
  output logic                                 m_tuser,   // [0] end_of_frame
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lapedge_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lapedge_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import lapedge_pkg::*;

  cfg_t cfg;
  logic accept;
  logic push;
  res_t core_res;
  res_t out_res;

  // Registers are always writable; an unknown index is acknowledged and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_threshold <= THR_RST;
      cfg.frame_width    <= FW_RST;
      cfg.frame_height   <= FH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: cfg.edge_threshold <= cfg_data[THR_W-1:0];
        CFG_WIDTH:     cfg.frame_width    <= cfg_data[FW_W-1:0];
        CFG_HEIGHT:    cfg.frame_height   <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Every request is taken as long as the output skid stage is empty.
  assign accept = s_tvalid && s_tready;

  lapedge_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .pixel  (s_tdata[PIX_W-1:0]),
    .drain  (s_tuser),
    .push   (push),
    .res    (core_res)
  );

  lapedge_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (core_res),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (out_res)
  );

  assign m_tdata = {7'b0000000, out_res.edge_res};
  assign m_tlast = out_res.end_of_row;
  assign m_tuser = out_res.end_of_frame;

endmodule

### test/tb_top.sv
// Testbench for the streaming Laplacian edge detector, self-checking against its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lapedge_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int RANDOM_ITEMS = 1040;
  // spare cycles after the last result before touching registers
  localparam int QUIET_CYCLES = 8;
  // cycles with no handshake on any channel before the run is abandoned
  localparam int STALL_LIMIT  = 2000;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] pixel
  logic                  s_tuser   = 1'b0; // [0] drain
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;          // [0] edge_res, [7:1] zero
  logic                  m_tlast;          // end_of_row
  logic                  m_tuser;          // [0] end_of_frame
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  laplacian_edge_threshold u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: two line stores, the previous centre and the raster
  // position, plus a shadow of the three registers as last written.
  // ---------------------------------------------------------------------------
  logic [7:0]  line_above [MAX_W];
  logic [7:0]  line_mid   [MAX_W];
  logic [7:0]  prev_centre = '0;
  int unsigned col_pos     = 0;
  int unsigned row_pos     = 0;
  logic [7:0]  thr_reg     = THR_RST;
  logic [11:0] width_reg   = FW_RST;
  logic [12:0] height_reg  = FH_RST;

  res_t        pending_edges [$];   // expected results, oldest first
  int unsigned items_taken = 0;     // requests that moved the raster on
  int unsigned errors      = 0;
  int unsigned burst_left  = 0;
  int unsigned noise_pct   = 0;     // share of out-of-place drain flags

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // Advance the raster by one request; returns 1 when it emits a result.
  // The emitted pixel is the one a row above, so the arriving pixel is its
  // lower neighbour; in the drain row the centre stands in for it.
  function automatic bit predict_edge(input logic [7:0] pix, input bit drn, output res_t r);
    int unsigned c;
    int          ctr, up, dn, lf, rt, lap;
    bit          last_col, drain_row, emits;
    c         = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    last_col  = (c + 1 >= eff_w());
    drain_row = (row_pos >= eff_h());
    emits     = 1'b0;
    r         = '0;
    // stray drain flag within the image rows: nothing happens
    if (!drain_row && drn) return 1'b0;
    if (drain_row || row_pos >= 1) begin
      ctr = int'(line_mid[c]);
      up  = (row_pos == 1) ? ctr : int'(line_above[c]);
      dn  = drain_row ? ctr : int'(pix);
      lf  = (c == 0) ? ctr : int'(prev_centre);
      rt  = last_col ? ctr : int'(line_mid[c + 1]);
      lap = 4 * ctr - up - dn - lf - rt;
      if (lap < 0) lap = 0;
      if (lap > 255) lap = 255;
      r.edge_res     = (lap > int'(thr_reg));
      r.end_of_row   = last_col;
      r.end_of_frame = last_col && drain_row;
      emits          = 1'b1;
      prev_centre    = ctr[7:0];
      if (!drain_row) begin
        line_above[c] = ctr[7:0];
        line_mid[c]   = pix;
      end
    end else begin
      line_mid[c] = pix;
    end
    if (last_col) begin
      col_pos = 0;
      if (drain_row) row_pos = 0;
      else row_pos = (row_pos + 1 >= eff_h()) ? eff_h() : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    return emits;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Stop sending and wait until every expected result is out, then give the
  // pipeline a few cycles to settle after requests that produced nothing.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_edges.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THRESHOLD: thr_reg    = val[7:0];
      CFG_WIDTH:     width_reg  = val[11:0];
      CFG_HEIGHT:    height_reg = val[12:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One request. The sender runs in bursts; between bursts it mostly drops valid for
  // a few cycles, and now and then holds off until the output has drained.
  task automatic send_item(input logic [7:0] pix, input bit drn);
    res_t r;
    bit   ignored;
    if (burst_left == 0) begin
      if ($urandom_range(199) == 0) begin
        wait_idle();
      end else if ($urandom_range(3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= drn;
    do @(posedge clk); while (!s_tready);
    ignored = drn && (row_pos < eff_h());
    if (predict_edge(pix, drn, r)) pending_edges.push_back(r);
    if (!ignored) items_taken++;
  endtask

  // Extremes are common so that responses cross every threshold.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Run the frame from wherever the raster stands to the end of its drain row,
  // with misplaced drain flags (pixels in the drain row) at the noise_pct rate.
  task automatic finish_frame();
    while (row_pos < eff_h()) begin
      if ($urandom_range(99) < noise_pct) send_item(8'($urandom_range(255)), 1'b1);
      else send_item(pick_pixel(), 1'b0);
    end
    do begin
      if ($urandom_range(99) < noise_pct) send_item(pick_pixel(), 1'b0);
      else send_item(8'($urandom_range(255)), 1'b1);
    end while (row_pos != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Threshold left at its reset value; a tiny frame of hard contrasts.
  task automatic test_reset_threshold();
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 2);
    send_item(8'd255, 1'b0);
    send_item(8'd0,   1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0,   1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0,   1'b0);
    finish_frame();
    wait_idle();
  endtask

  // Drain flag during image rows is dropped; a pixel in the drain row is
  // treated as a drain request and its value discarded.
  task automatic test_drain_handling();
    write_reg(CFG_THRESHOLD, 60);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 1);
    send_item(8'd255, 1'b1);
    send_item(8'd200, 1'b0);
    send_item(8'd10,  1'b1);
    send_item(8'd0,   1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd77,  1'b1);
    wait_idle();
  endtask

  // Zero width and zero height both act as one.
  task automatic test_degenerate_sizes();
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    send_item(8'd200, 1'b0);
    send_item(8'd0,   1'b1);
    wait_idle();
  endtask

  // At the top threshold nothing can be marked.
  task automatic test_threshold_top();
    write_reg(CFG_THRESHOLD, 255);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 1);
    send_item(8'd255, 1'b0);
    send_item(8'd0,   1'b0);
    finish_frame();
    wait_idle();
  endtask

  // Sizes shrink while a frame is under way: the column already past the new
  // width ends its row, and a row count past the new height starts the drain.
  task automatic test_mid_frame_resize();
    write_reg(CFG_THRESHOLD, 40);
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 4);
    repeat (10) send_item(pick_pixel(), 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 1);
    send_item(8'd255, 1'b0);
    wait_idle();
    write_reg(CFG_HEIGHT, 2);
    finish_frame();
    wait_idle();
  endtask

  // Largest sizes the fields can hold: width clamps to the line length, so a
  // short run never ends the row. Each frame is then cut short by shrinking.
  task automatic test_extreme_geometry();
    write_reg(CFG_THRESHOLD, 100);
    write_reg(CFG_WIDTH, 4095);
    write_reg(CFG_HEIGHT, 0);
    repeat (30) send_item(pick_pixel(), 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 24);
    finish_frame();
    wait_idle();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 8191);
    repeat (5) send_item(pick_pixel(), 1'b0);
    wait_idle();
    write_reg(CFG_HEIGHT, 2);
    finish_frame();
    wait_idle();
  endtask

  // Random small frames with random settings and some misplaced drain flags.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned val;
    goal      = items_taken + RANDOM_ITEMS;
    noise_pct = 6;
    while (items_taken < goal) begin
      wait_idle();
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(9))
          0:       val = 0;
          1:       val = 255;
          default: val = $urandom_range(255);
        endcase
        write_reg(CFG_THRESHOLD, val);
      end
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0:       val = 0;
          1, 2:    val = $urandom_range(11, 40);
          default: val = $urandom_range(1, 10);
        endcase
        write_reg(CFG_WIDTH, val);
      end
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0:       val = 0;
          1, 2:    val = $urandom_range(7, 20);
          default: val = $urandom_range(1, 6);
        endcase
        write_reg(CFG_HEIGHT, val);
      end
      finish_frame();
    end
    noise_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that changes every so often - always
  // ready, coin toss, or one cycle in four.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned phase      = 0;
  res_t        want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_edges.size() == 0) begin
        $display("%t unexpected result: expected none, got edge %0b row %0b frame %0b",
                 $time, m_tdata[0], m_tlast, m_tuser);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (m_tdata !== {7'd0, want.edge_res}) begin
          $display("%t edge_res: expected %0d, got %0d", $time, want.edge_res, m_tdata);
          errors++;
        end
        if (m_tlast !== want.end_of_row) begin
          $display("%t end_of_row: expected %0b, got %0b", $time, want.end_of_row, m_tlast);
          errors++;
        end
        if (m_tuser !== want.end_of_frame) begin
          $display("%t end_of_frame: expected %0b, got %0b", $time, want.end_of_frame, m_tuser);
          errors++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(2);
      mode_left  = $urandom_range(8, 120);
    end
    mode_left--;
    phase++;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(1));
      default: m_tready <= (phase % 4 == 0);
    endcase
  end

  // Watchdog: any handshake on any channel counts as progress.
  int unsigned quiet_count = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= STALL_LIMIT) begin
      $display("%t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_threshold();
    test_drain_handling();
    test_degenerate_sizes();
    test_threshold_top();
    test_mid_frame_resize();
    test_extreme_geometry();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
